// ===== rtl/nswf_pkg.sv =====
// Package for near_square_wheel_features: widths, the wheel primes,
// the feature and tail structs and the residue step function. No dependencies.
package nswf_pkg;

   localparam int SCORE_FRAC_BITS = 16;
   localparam int N_W             = 64;
   localparam int SCORE_W         = 17;
   localparam int GAP_W           = 33;
   localparam int NUM_PRIMES      = 6;
   localparam int ROOT_N_STEPS    = N_W / 2;

   localparam logic [NUM_PRIMES-1:0][3:0] PRIMES =
      {4'd13, 4'd11, 4'd7, 4'd5, 4'd3, 4'd2};

   typedef struct packed {
      logic                        tiny;
      logic [NUM_PRIMES-1:0]       gt;
      logic [NUM_PRIMES-1:0][3:0]  res;
   } feat_type;

   typedef struct packed {
      logic tiny;
      logic square;
      logic wheel;
   } tail_type;

   // (r*4 + d) mod p for r < p
   function automatic logic [3:0] mod_step(logic [3:0] r, logic [1:0] d, logic [3:0] p);
      logic [5:0] v;
      v = {r, 2'b00} + {4'b0000, d};
      for (int k = 0; k < 3; k++) begin
         if (v >= {2'b00, p}) begin
            v = v - {2'b00, p};
         end
      end
      return v[3:0];
   endfunction

endpackage

// ===== rtl/near_square_wheel_features.sv =====
// near_square_wheel_features: cheap features of an unsigned 64-bit number N.
// Top level; uses nswf_pkg, nswf_sqrt_stage and nswf_div_stage.
//
// Input channel req_valid/req_ready carries req_n_value. Result channel
// rsp_valid/rsp_ready carries rsp_near_square_score (2^F = 1.0),
// rsp_square_flag and rsp_wheel_divisible. One result per item, in order.
// For N <= 1 all result fields are zero.
// Datapath: a square root of N*2^(2F), one root bit per stage (32+F stages);
// the remainder after the first 32 stages is the gap N - floor(sqrt(N))^2,
// and the wheel residues are built two bits per stage alongside. Then a
// restoring divider, one quotient bit per stage (F+2 stages).
// Throughput: one item per cycle while the result channel is not stalled.
// The whole pipeline advances together; when the last stage holds an item
// and rsp_ready is low, every stage holds and req_ready is low, so nothing
// is lost or repeated. Reset (synchronous, active high) clears all valid
// bits; the pipeline is empty and ready on the next cycle.
module near_square_wheel_features #(
   parameter int SCORE_FRAC_BITS = nswf_pkg::SCORE_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_n_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [16:0] rsp_near_square_score,
   output logic        rsp_square_flag,
   output logic        rsp_wheel_divisible
);
   import nswf_pkg::*;

   localparam int F    = SCORE_FRAC_BITS;
   localparam int XW   = N_W + 2*F;
   localparam int RW   = 32 + F;
   localparam int REMW = RW + 2;
   localparam int NW   = 32 + 2*F;
   localparam int DW   = 34 + F;
   localparam int QW   = F + 2;

   logic enable;

   logic             sv [RW+1];
   logic [XW-1:0]    sx [RW+1];
   logic [REMW-1:0]  srem [RW+1];
   logic [RW-1:0]    sroot [RW+1];
   logic [GAP_W-1:0] sgap [RW+1];
   feat_type         sfeat [RW+1];

   logic             dv [QW+1];
   logic [NW-1:0]    dnum [QW+1];
   logic [DW-1:0]    dden [QW+1];
   logic [QW-1:0]    dq [QW+1];
   tail_type         dtail [QW+1];

   assign enable    = !dv[QW] || rsp_ready;
   assign req_ready = enable;

   always_comb begin
      sv[0]    = req_valid;
      sx[0]    = {req_n_value, {(2*F){1'b0}}};
      srem[0]  = '0;
      sroot[0] = '0;
      sgap[0]  = '0;
      sfeat[0].tiny = (req_n_value <= 64'd1);
      for (int k = 0; k < NUM_PRIMES; k++) begin
         sfeat[0].gt[k]  = (req_n_value > 64'(PRIMES[k]));
         sfeat[0].res[k] = 4'd0;
      end
   end

   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      nswf_sqrt_stage #(.FRAC(F), .STEP(i)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .in_valid (sv[i]),
         .in_x     (sx[i]),
         .in_rem   (srem[i]),
         .in_root  (sroot[i]),
         .in_gap   (sgap[i]),
         .in_feat  (sfeat[i]),
         .out_valid(sv[i+1]),
         .out_x    (sx[i+1]),
         .out_rem  (srem[i+1]),
         .out_root (sroot[i+1]),
         .out_gap  (sgap[i+1]),
         .out_feat (sfeat[i+1])
      );
   end

   always_comb begin
      dv[0]   = sv[RW];
      dnum[0] = NW'(sroot[RW]) << F;
      dden[0] = DW'(sroot[RW]) + (DW'(sgap[RW]) << F);
      dq[0]   = '0;
      dtail[0].tiny   = sfeat[RW].tiny;
      dtail[0].square = (sgap[RW] == '0);
      dtail[0].wheel  = 1'b0;
      for (int k = 0; k < NUM_PRIMES; k++) begin
         if (sfeat[RW].gt[k] && sfeat[RW].res[k] == 4'd0) begin
            dtail[0].wheel = 1'b1;
         end
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_div
      nswf_div_stage #(.FRAC(F), .BIT(QW-1-j)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .in_valid (dv[j]),
         .in_num   (dnum[j]),
         .in_den   (dden[j]),
         .in_q     (dq[j]),
         .in_tail  (dtail[j]),
         .out_valid(dv[j+1]),
         .out_num  (dnum[j+1]),
         .out_den  (dden[j+1]),
         .out_q    (dq[j+1]),
         .out_tail (dtail[j+1])
      );
   end

   assign rsp_valid             = dv[QW];
   assign rsp_near_square_score = dtail[QW].tiny ? '0 : SCORE_W'(dq[QW]);
   assign rsp_square_flag       = !dtail[QW].tiny && dtail[QW].square;
   assign rsp_wheel_divisible   = !dtail[QW].tiny && dtail[QW].wheel;

endmodule

// ===== rtl/nswf_sqrt_stage.sv =====
// One radix-2 digit step of the pipelined square root, with the wheel residues
// and gap capture riding along. Depends on nswf_pkg.
module nswf_sqrt_stage #(
   parameter int FRAC = 16,
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  logic [64+2*FRAC-1:0]   in_x,
   input  logic [34+FRAC-1:0]     in_rem,
   input  logic [32+FRAC-1:0]     in_root,
   input  logic [32:0]            in_gap,
   input  nswf_pkg::feat_type     in_feat,
   output logic                   out_valid,
   output logic [64+2*FRAC-1:0]   out_x,
   output logic [34+FRAC-1:0]     out_rem,
   output logic [32+FRAC-1:0]     out_root,
   output logic [32:0]            out_gap,
   output nswf_pkg::feat_type     out_feat
);
   import nswf_pkg::*;

   localparam int XW   = 64 + 2*FRAC;
   localparam int RW   = 32 + FRAC;
   localparam int REMW = RW + 2;
   localparam bit N_STEP   = (STEP < ROOT_N_STEPS);
   localparam bit GAP_STEP = (STEP == ROOT_N_STEPS - 1);

   logic [1:0]      two;
   logic [REMW-1:0] cur, trial;
   logic            valid_ff, valid_in;
   logic [XW-1:0]   x_ff, x_in;
   logic [REMW-1:0] rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [GAP_W-1:0] gap_ff, gap_in;
   feat_type        feat_ff, feat_in;

   always_comb begin
      two      = in_x[XW-1 -: 2];
      x_in     = in_x << 2;
      cur      = {in_rem[REMW-3:0], two};
      trial    = {in_root, 2'b01};
      valid_in = in_valid;
      if (cur >= trial) begin
         rem_in  = cur - trial;
         root_in = {in_root[RW-2:0], 1'b1};
      end else begin
         rem_in  = cur;
         root_in = {in_root[RW-2:0], 1'b0};
      end
      gap_in  = GAP_STEP ? rem_in[GAP_W-1:0] : in_gap;
      feat_in = in_feat;
      if (N_STEP) begin
         for (int k = 0; k < NUM_PRIMES; k++) begin
            feat_in.res[k] = mod_step(in_feat.res[k], two, PRIMES[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         x_ff    <= x_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         gap_ff  <= gap_in;
         feat_ff <= feat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_gap   = gap_ff;
   assign out_feat  = feat_ff;

endmodule

// ===== rtl/nswf_div_stage.sv =====
// One restoring division step producing one quotient bit of the score.
// Depends on nswf_pkg.
module nswf_div_stage #(
   parameter int FRAC = 16,
   parameter int BIT  = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  logic [32+2*FRAC-1:0] in_num,
   input  logic [34+FRAC-1:0]   in_den,
   input  logic [FRAC+1:0]      in_q,
   input  nswf_pkg::tail_type   in_tail,
   output logic                 out_valid,
   output logic [32+2*FRAC-1:0] out_num,
   output logic [34+FRAC-1:0]   out_den,
   output logic [FRAC+1:0]      out_q,
   output nswf_pkg::tail_type   out_tail
);
   import nswf_pkg::*;

   localparam int NW = 32 + 2*FRAC;
   localparam int DW = 34 + FRAC;
   localparam int QW = FRAC + 2;
   localparam logic [NW-1:0] LOW_MASK = (NW'(1) << BIT) - NW'(1);
   localparam logic [QW-1:0] Q_BIT    = QW'(1) << BIT;

   logic [NW-1:0] hi, den_x, diff;
   logic          valid_ff;
   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff;
   logic [QW-1:0] q_ff, q_in;
   tail_type      tail_ff;

   always_comb begin
      hi    = in_num >> BIT;
      den_x = NW'(in_den);
      diff  = hi - den_x;
      if (hi >= den_x) begin
         num_in = (diff << BIT) | (in_num & LOW_MASK);
         q_in   = in_q | Q_BIT;
      end else begin
         num_in = in_num;
         q_in   = in_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         num_ff  <= num_in;
         den_ff  <= in_den;
         q_ff    <= q_in;
         tail_ff <= in_tail;
      end
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_q     = q_ff;
   assign out_tail  = tail_ff;

endmodule
